// File: design/abc_pkg.sv
package abc_pkg;

	typedef struct packed {
		logic        operation;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;

	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_0    = 3'd1;
	localparam logic [2:0] REG_KEY_1    = 3'd2;
	localparam logic [2:0] REG_KEY_2    = 3'd3;
	localparam logic [2:0] REG_KEY_3    = 3'd4;

	localparam int NR_MAX  = 14;
	localparam int NW_MAX  = 60;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gf_mul = p;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = x;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gf_mul(r, b);
			b = gf_mul(b, b);
		end
		gf_inv = r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		rotl8 = (v << n) | (v >> (8 - n));
	endfunction

	// constant tables, evaluated per entry as case-free functions of the index
	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] b;
		b = gf_inv(x);
		sbox = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] s);
		inv_sbox = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		sbox_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// one full round on a 16-byte state, byte 0 in the top bits
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0] t [16];
		logic [7:0] u [16];
		logic [127:0] r;
		for (int i = 0; i < 16; i++) t[i] = sbox(s[127-8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int q = 0; q < 4; q++)
				u[4*c+q] = t[4*((c+q)%4)+q];
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int q = 0; q < 4; q++) r[127-8*(4*c+q) -: 8] = u[4*c+q];
			end else begin
				r[127-32*c -: 8] = xtime(u[4*c]) ^ xtime(u[4*c+1]) ^ u[4*c+1]
					^ u[4*c+2] ^ u[4*c+3];
				r[119-32*c -: 8] = u[4*c] ^ xtime(u[4*c+1]) ^ xtime(u[4*c+2])
					^ u[4*c+2] ^ u[4*c+3];
				r[111-32*c -: 8] = u[4*c] ^ u[4*c+1] ^ xtime(u[4*c+2])
					^ xtime(u[4*c+3]) ^ u[4*c+3];
				r[103-32*c -: 8] = xtime(u[4*c]) ^ u[4*c] ^ u[4*c+1] ^ u[4*c+2]
					^ xtime(u[4*c+3]);
			end
		end
		enc_round = r ^ k;
	endfunction

	function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
			input logic last);
		logic [7:0] t [16];
		logic [7:0] u [16];
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int q = 0; q < 4; q++)
				t[4*c+q] = s[127-8*(4*((c+4-q)%4)+q) -: 8];
		for (int i = 0; i < 16; i++) u[i] = inv_sbox(t[i]) ^ k[127-8*i -: 8];
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int q = 0; q < 4; q++) r[127-8*(4*c+q) -: 8] = u[4*c+q];
			end else begin
				for (int q = 0; q < 4; q++)
					r[127-8*(4*c+q) -: 8] = gf_mul(u[4*c+q], 8'h0e)
						^ gf_mul(u[4*c+(q+1)%4], 8'h0b)
						^ gf_mul(u[4*c+(q+2)%4], 8'h0d)
						^ gf_mul(u[4*c+(q+3)%4], 8'h09);
			end
		end
		dec_round = r;
	endfunction

endpackage

// File: design/aes_block_cipher.sv
// Channel   Dir  Handshake        Payload
// in        in   valid / ready    abc_pkg::in_item_t  (operation, block)
// out       out  valid / ready    abc_pkg::out_item_t (result)
// cfg       in   APB psel/penable abc_pkg register map, 8-byte stride
//
// Round pipeline of 15 stages (one per round plus initial key add); one block
// per cycle while the output is not stalled. Shorter keys pass through the unused tail stages.
// Round keys are expanded by a sequencer, one word per cycle, after reset or
// any register write; input is held off until the schedule is complete.
// A stall of the output freezes the whole pipe; nothing is dropped or repeated.
module aes_block_cipher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  abc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output abc_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	localparam int NS = abc_pkg::NR_MAX + 1;

	logic [1:0]  key_size_q;
	logic [63:0] key_q [4];
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				abc_pkg::REG_KEY_SIZE: key_size_q <= pwdata[1:0];
				abc_pkg::REG_KEY_0:    key_q[0] <= pwdata;
				abc_pkg::REG_KEY_1:    key_q[1] <= pwdata;
				abc_pkg::REG_KEY_2:    key_q[2] <= pwdata;
				abc_pkg::REG_KEY_3:    key_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			abc_pkg::REG_KEY_SIZE: prdata = {62'd0, key_size_q};
			abc_pkg::REG_KEY_0:    prdata = key_q[0];
			abc_pkg::REG_KEY_1:    prdata = key_q[1];
			abc_pkg::REG_KEY_2:    prdata = key_q[2];
			abc_pkg::REG_KEY_3:    prdata = key_q[3];
			default:               prdata = '0;
		endcase
	end

	// key expansion sequencer: one word per cycle into the round-key registers
	logic [127:0] rk_q [NS];
	logic [31:0]  win_q [8];
	logic [5:0]   widx_q;
	logic         kbusy_q;
	logic [7:0]   rc_q;
	logic [3:0]   nk;
	logic [3:0]   ksub_q;
	logic [31:0]  wnew;
	logic [31:0]  wcur;
	logic [31:0]  wprev;
	logic [31:0]  t;
	logic [3:0]   nr;

	always_comb begin
		case (key_size_q)
			abc_pkg::KS_128: begin nk = 4'd4; nr = 4'd10; end
			abc_pkg::KS_192: begin nk = 4'd6; nr = 4'd12; end
			default:         begin nk = 4'd8; nr = 4'd14; end
		endcase
	end

	// win_q[j] holds schedule word i-1-j
	assign wprev = win_q[0];
	always_comb begin
		t = wprev;
		if (ksub_q == 4'd0)
			t = abc_pkg::sbox_word({wprev[23:0], wprev[31:24]}) ^ {rc_q, 24'd0};
		else if (nk == 4'd8 && ksub_q == 4'd4)
			t = abc_pkg::sbox_word(wprev);
		wnew = win_q[3'(nk - 4'd1)] ^ t;
		if (widx_q < 6'({2'd0, nk}))
			wcur = widx_q[0] ? key_q[widx_q[2:1]][31:0] : key_q[widx_q[2:1]][63:32];
		else
			wcur = wnew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbusy_q <= 1'b1;
			widx_q  <= '0;
			ksub_q  <= '0;
			rc_q    <= 8'h01;
		end else if (cfg_wr) begin
			kbusy_q <= 1'b1;
			widx_q  <= '0;
			ksub_q  <= '0;
			rc_q    <= 8'h01;
		end else if (kbusy_q) begin
			widx_q <= widx_q + 6'd1;
			ksub_q <= (ksub_q == nk - 4'd1) ? 4'd0 : ksub_q + 4'd1;
			if (widx_q >= 6'({2'd0, nk}) && ksub_q == 4'd0) rc_q <= abc_pkg::xtime(rc_q);
			if (widx_q == 6'(abc_pkg::NW_MAX - 1)) kbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (kbusy_q && !cfg_wr) begin
			win_q[0] <= wcur;
			for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
			rk_q[widx_q[5:2]][{~widx_q[1:0], 5'd0} +: 32] <= wcur;
		end
	end

	logic         adv;
	logic         v_s [NS];
	logic         op_s [NS];
	logic [127:0] st_s [NS];
	logic [3:0]   nr_s [NS];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv && !kbusy_q;
	assign out_valid = v_s[NS-1];
	assign out_data  = {st_s[NS-1][127:64], st_s[NS-1][63:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid && !kbusy_q;
			for (int i = 1; i < NS; i++) v_s[i] <= v_s[i-1];
		end
	end

	// stage 0: initial key add; stage r: round r, skipped past nr
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0] <= in_data.operation;
			nr_s[0] <= nr;
			st_s[0] <= {in_data.block_high, in_data.block_low}
				^ (in_data.operation ? rk_q[nr] : rk_q[0]);
			for (int r = 1; r < NS; r++) begin
				op_s[r] <= op_s[r-1];
				nr_s[r] <= nr_s[r-1];
				if (4'(r) > nr_s[r-1])
					st_s[r] <= st_s[r-1];
				else if (!op_s[r-1])
					st_s[r] <= abc_pkg::enc_round(st_s[r-1], rk_q[r], 4'(r) == nr_s[r-1]);
				else
					st_s[r] <= abc_pkg::dec_round(st_s[r-1],
						rk_q[nr_s[r-1] - 4'(r)], 4'(r) == nr_s[r-1]);
			end
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kbusy_q |-> !in_ready) else $error("accept during key expansion");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> kbusy_q && widx_q == 6'd0) else $error("key schedule not restarted");

endmodule

// File: bench/tb_aes_block_cipher.sv
`timescale 1ns / 100ps

module tb_aes_block_cipher;

	localparam int LATENCY = 20;
	localparam logic [1:0] KS_RSVD = 2'd3;

	typedef struct {
		logic [1:0]  ks;
		logic [63:0] k0, k1, k2, k3;
		logic        op;
		logic [63:0] hi, lo;
		logic        known;
		logic [63:0] exp_hi, exp_lo;
	} vector_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	abc_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	abc_pkg::out_item_t out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;

	aes_block_cipher uut (.*);

	always #10 clk = ~clk;

	// shadow of the key registers and the round keys they give
	logic [1:0]   cur_size = abc_pkg::KS_128;
	logic [63:0]  cur_key [4] = '{default: '0};
	logic [127:0] round_keys [15];
	int           cur_rounds;

	logic [7:0] fwd_box [256];
	logic [7:0] inv_box [256];

	abc_pkg::out_item_t pending_results [$];
	int                 fail_count = 0;
	int                 tx_idle = 0;
	int                 rx_idle = 0;
	int                 rx_mode = 0;
	logic               typed_valid = 1'b0;
	abc_pkg::out_item_t typed_result;
	vector_t            vectors [14];

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic void build_boxes();
		logic [7:0] v, b;
		for (int x = 0; x < 256; x++) begin
			b = 8'h01;
			for (int e = 0; e < 254; e++) b = gmul(b, x[7:0]);
			v = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
			fwd_box[x] = v;
			inv_box[v] = x[7:0];
		end
	endfunction

	function automatic logic [31:0] subst_word(logic [31:0] w);
		return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		int nk;
		nk = (cur_size == abc_pkg::KS_128) ? 4 : (cur_size == abc_pkg::KS_192) ? 6 : 8;
		cur_rounds = nk + 6;
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			w[i] = (i % 2) ? cur_key[i/2][31:0] : cur_key[i/2][63:32];
		for (int i = nk; i < 4 * (cur_rounds + 1); i++) begin
			t = w[i-1];
			if (i % nk == 0) begin
				t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gmul(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				t = subst_word(t);
			end
			w[i] = w[i-nk] ^ t;
		end
		for (int r = 0; r <= cur_rounds; r++)
			round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	function automatic logic [127:0] substitute(logic [127:0] v, logic inv);
		for (int i = 0; i < 16; i++)
			v[127-8*i -: 8] = inv ? inv_box[v[127-8*i -: 8]] : fwd_box[v[127-8*i -: 8]];
		return v;
	endfunction

	function automatic logic [127:0] shift_state(logic [127:0] v, logic inv);
		logic [127:0] o;
		int src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
				o[127-8*(4*c+r) -: 8] = v[127-8*(4*src+r) -: 8];
			end
		return o;
	endfunction

	function automatic logic [127:0] mix_state(logic [127:0] v, logic inv);
		logic [7:0] coef [4];
		logic [7:0] acc;
		logic [127:0] o;
		if (inv)
			coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = '0;
				for (int k = 0; k < 4; k++)
					acc ^= gmul(v[127-8*(4*c+k) -: 8], coef[(k - r + 4) % 4]);
				o[127-8*(4*c+r) -: 8] = acc;
			end
		return o;
	endfunction

	function automatic abc_pkg::out_item_t aes_predict(abc_pkg::in_item_t req);
		logic [127:0] s;
		s = {req.block_high, req.block_low};
		if (!req.operation) begin
			s ^= round_keys[0];
			for (int r = 1; r < cur_rounds; r++)
				s = mix_state(shift_state(substitute(s, 0), 0), 0) ^ round_keys[r];
			s = shift_state(substitute(s, 0), 0) ^ round_keys[cur_rounds];
		end else begin
			s ^= round_keys[cur_rounds];
			for (int r = cur_rounds - 1; r >= 1; r--)
				s = mix_state(substitute(shift_state(s, 1), 1) ^ round_keys[r], 1);
			s = substitute(shift_state(s, 1), 1) ^ round_keys[0];
		end
		return '{result_high: s[127:64], result_low: s[63:0]};
	endfunction

	// record each accepted request
	always @(posedge clk) begin
		if (in_valid && in_ready)
			pending_results.push_back(typed_valid ? typed_result : aes_predict(in_data));
	end

	// result checker and receiver pacing
	logic hold_done = 1'b0;
	int   hold_left = 0;
	always @(posedge clk) begin
		abc_pkg::out_item_t exp_item;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", out_data);
				fail_count++;
			end else begin
				exp_item = pending_results.pop_front();
				if (out_data.result_high !== exp_item.result_high) begin
					$error("result_high expected %h actual %h",
						exp_item.result_high, out_data.result_high);
					fail_count++;
				end
				if (out_data.result_low !== exp_item.result_low) begin
					$error("result_low expected %h actual %h",
						exp_item.result_low, out_data.result_low);
					fail_count++;
				end
			end
		end
		if (rx_mode == 2 && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// the bus stays selected between transfers; load_key releases it
	task automatic apb_write(input logic [5:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic [5:0] addr, input logic [63:0] want,
			input logic [63:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (want & mask)) begin
			$error("register %0d expected %h actual %h", addr / 8, want & mask, prdata & mask);
			fail_count++;
		end
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// upper bits of the size word may be junk; only the low two count
	task automatic load_key(input logic [63:0] size_word, input logic [63:0] k0,
			input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
		logic [63:0] vals [5];
		vals = '{size_word, k0, k1, k2, k3};
		wait_idle();
		for (int i = 0; i < 5; i++) apb_write(6'(8 * i), vals[i]);
		// addresses past the map must be ignored
		apb_write(6'(8 * 5), {$urandom, $urandom});
		apb_write(6'(8 * 7), {$urandom, $urandom});
		cur_size = size_word[1:0];
		cur_key = '{k0, k1, k2, k3};
		expand_round_keys();
		apb_check(6'(8 * abc_pkg::REG_KEY_SIZE), {62'h0, cur_size}, 64'h3);
		for (int i = 0; i < 4; i++) apb_check(6'(8 * (i + 1)), cur_key[i], '1);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send(input abc_pkg::in_item_t req);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	localparam logic [63:0] ONES = 64'hffffffffffffffff;
	localparam logic [63:0] PT_H = 64'h0011223344556677;
	localparam logic [63:0] PT_L = 64'h8899aabbccddeeff;
	localparam logic [63:0] KA = 64'h0001020304050607;
	localparam logic [63:0] KB = 64'h08090a0b0c0d0e0f;
	localparam logic [63:0] KC = 64'h1011121314151617;
	localparam logic [63:0] KD = 64'h18191a1b1c1d1e1f;

	initial begin
		abc_pkg::in_item_t req;
		build_boxes();
		expand_round_keys();
		// known answers come from the standard's example vectors
		vectors = '{
			'{abc_pkg::KS_128, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 0, 0},
			'{abc_pkg::KS_128, 0, 0, 0, 0, 1'b1, ONES, ONES, 1'b0, 0, 0},
			'{abc_pkg::KS_128, 0, 0, 0, 0, 1'b0, ONES, ONES, 1'b0, 0, 0},
			'{abc_pkg::KS_128, KA, KB, ONES, ONES, 1'b0, PT_H, PT_L, 1'b1,
				64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
			'{abc_pkg::KS_128, KA, KB, ONES, ONES, 1'b1, 64'h69c4e0d86a7b0430,
				64'hd8cdb78070b4c55a, 1'b1, PT_H, PT_L},
			'{abc_pkg::KS_192, KA, KB, KC, ONES, 1'b0, PT_H, PT_L, 1'b1,
				64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
			'{abc_pkg::KS_192, KA, KB, KC, ONES, 1'b1, 64'hdda97ca4864cdfe0,
				64'h6eaf70a0ec0d7191, 1'b1, PT_H, PT_L},
			'{abc_pkg::KS_256, KA, KB, KC, KD, 1'b0, PT_H, PT_L, 1'b1,
				64'h8ea2b7ca516745bf, 64'heafc49904b496089},
			'{abc_pkg::KS_256, KA, KB, KC, KD, 1'b1, 64'h8ea2b7ca516745bf,
				64'heafc49904b496089, 1'b1, PT_H, PT_L},
			// undefined size code behaves as the 256-bit key
			'{KS_RSVD, KA, KB, KC, KD, 1'b0, PT_H, PT_L, 1'b1,
				64'h8ea2b7ca516745bf, 64'heafc49904b496089},
			'{KS_RSVD, KA, KB, KC, KD, 1'b1, 64'h8ea2b7ca516745bf,
				64'heafc49904b496089, 1'b1, PT_H, PT_L},
			'{abc_pkg::KS_256, ONES, ONES, ONES, ONES, 1'b0, ONES, ONES, 1'b0, 0, 0},
			'{abc_pkg::KS_256, ONES, ONES, ONES, ONES, 1'b1, 0, 0, 1'b0, 0, 0},
			'{abc_pkg::KS_192, ONES, ONES, ONES, ONES, 1'b0, ONES, 0, 1'b0, 0, 0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) begin
			if (vectors[i].ks != cur_size || vectors[i].k0 != cur_key[0]
					|| vectors[i].k1 != cur_key[1] || vectors[i].k2 != cur_key[2]
					|| vectors[i].k3 != cur_key[3]) begin
				in_valid <= 1'b0;
				load_key({62'h0, vectors[i].ks}, vectors[i].k0, vectors[i].k1,
					vectors[i].k2, vectors[i].k3);
			end
			// takes effect after the monitor has seen the previous request
			typed_valid <= vectors[i].known;
			typed_result <= '{vectors[i].exp_hi, vectors[i].exp_lo};
			send('{vectors[i].op, vectors[i].hi, vectors[i].lo});
		end
		typed_valid <= 1'b0;

		for (int mode = 0; mode < 3; mode++) begin
			tx_idle = (mode == 0) ? 29 : (mode == 1) ? 51 : 0;
			rx_idle = (mode == 0) ? 51 : (mode == 1) ? 29 : 0;
			rx_mode = mode;
			for (int seg = 0; seg < 2; seg++) begin
				in_valid <= 1'b0;
				load_key({$urandom, $urandom}, rand_word(), rand_word(),
					rand_word(), rand_word());
				for (int n = 0; n < 273; n++) begin
					req.operation = $urandom_range(1);
					req.block_high = rand_word();
					req.block_low = rand_word();
					send(req);
				end
			end
		end
		in_valid <= 1'b0;

		wait_idle();
		if (fail_count == 0)
			$display("aes_block_cipher verification clean");
		else
			$display("aes_block_cipher verification failed");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("aes_block_cipher verification failed");
		$finish;
	end

endmodule
